// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the calibration solver.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/tacs_pkg.sv =====
// Shared types, constants and the solve microprogram of the calibration solver.
// No dependencies.
`default_nettype none
package tacs_pkg;

	localparam int NUM_POINTS_DEF = 5;
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int W          = 128;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 216;
	localparam int COEF_W     = 32;
	localparam int NCOEF      = 6;
	localparam int SCALE_W    = 17;
	localparam int UPC_W      = 6;
	localparam int NREG       = 19;

	localparam logic [COEF_W-1:0] SAT_MIN = 32'h8000_0000;
	localparam logic [COEF_W-1:0] SAT_MAX = 32'h7FFF_FFFF;

	localparam logic MAC_ADD = 1'b0;
	localparam logic MAC_SUB = 1'b1;

	typedef enum logic [2:0] {
		OP_SUM, OP_MAC, OP_ST, OP_ZT, OP_DIV, OP_END
	} op_t;

	typedef enum logic [2:0] {
		SRC_ONE, SRC_RX, SRC_RY, SRC_SX, SRC_SY
	} src_t;

	typedef enum logic [4:0] {
		R_N, R_SX, R_SY, R_SXX, R_SYY, R_SXY,
		R_ZX0, R_ZXX, R_ZXY, R_ZY0, R_ZYX, R_ZYY,
		R_A, R_B, R_C, R_E, R_F, R_I, R_DET
	} reg_t;

	typedef enum logic [2:0] {
		C_XOFF, C_XRX, C_XRY, C_YOFF, C_YRX, C_YRY
	} coef_t;

	typedef struct packed {
		op_t   opc;
		reg_t  ra;
		reg_t  rb;
		logic  neg;
		src_t  p;
		src_t  q;
		coef_t cidx;
	} uop_t;

	typedef struct packed {
		logic go;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic det_zero;
	} stat_t;

	typedef struct packed {
		logic valid;
		logic ok;
	} pub_t;

	function automatic uop_t u_sum(src_t p, src_t q, reg_t d);
		uop_t u;
		u = '0;
		u.opc = OP_SUM;
		u.p = p;
		u.q = q;
		u.ra = d;
		return u;
	endfunction

	function automatic uop_t u_mac(reg_t a, reg_t b, logic neg);
		uop_t u;
		u = '0;
		u.opc = OP_MAC;
		u.ra = a;
		u.rb = b;
		u.neg = neg;
		return u;
	endfunction

	function automatic uop_t u_op(op_t opc, reg_t d, coef_t c);
		uop_t u;
		u = '0;
		u.opc = opc;
		u.ra = d;
		u.cidx = c;
		return u;
	endfunction

	// Solve sequence: point sums, adjugate, determinant, zero test, six quotients.
	function automatic uop_t ucode(logic [UPC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = u_sum(SRC_ONE, SRC_ONE, R_N);
			6'd1:  u = u_sum(SRC_RX, SRC_ONE, R_SX);
			6'd2:  u = u_sum(SRC_RY, SRC_ONE, R_SY);
			6'd3:  u = u_sum(SRC_RX, SRC_RX, R_SXX);
			6'd4:  u = u_sum(SRC_RY, SRC_RY, R_SYY);
			6'd5:  u = u_sum(SRC_RX, SRC_RY, R_SXY);
			6'd6:  u = u_sum(SRC_SX, SRC_ONE, R_ZX0);
			6'd7:  u = u_sum(SRC_SX, SRC_RX, R_ZXX);
			6'd8:  u = u_sum(SRC_SX, SRC_RY, R_ZXY);
			6'd9:  u = u_sum(SRC_SY, SRC_ONE, R_ZY0);
			6'd10: u = u_sum(SRC_SY, SRC_RX, R_ZYX);
			6'd11: u = u_sum(SRC_SY, SRC_RY, R_ZYY);
			6'd12: u = u_mac(R_SXX, R_SYY, MAC_ADD);
			6'd13: u = u_mac(R_SXY, R_SXY, MAC_SUB);
			6'd14: u = u_op(OP_ST, R_A, C_XOFF);
			6'd15: u = u_mac(R_SXY, R_SY, MAC_ADD);
			6'd16: u = u_mac(R_SYY, R_SX, MAC_SUB);
			6'd17: u = u_op(OP_ST, R_B, C_XOFF);
			6'd18: u = u_mac(R_SXY, R_SX, MAC_ADD);
			6'd19: u = u_mac(R_SXX, R_SY, MAC_SUB);
			6'd20: u = u_op(OP_ST, R_C, C_XOFF);
			6'd21: u = u_mac(R_SYY, R_N, MAC_ADD);
			6'd22: u = u_mac(R_SY, R_SY, MAC_SUB);
			6'd23: u = u_op(OP_ST, R_E, C_XOFF);
			6'd24: u = u_mac(R_SX, R_SY, MAC_ADD);
			6'd25: u = u_mac(R_SXY, R_N, MAC_SUB);
			6'd26: u = u_op(OP_ST, R_F, C_XOFF);
			6'd27: u = u_mac(R_SXX, R_N, MAC_ADD);
			6'd28: u = u_mac(R_SX, R_SX, MAC_SUB);
			6'd29: u = u_op(OP_ST, R_I, C_XOFF);
			6'd30: u = u_mac(R_A, R_N, MAC_ADD);
			6'd31: u = u_mac(R_B, R_SX, MAC_ADD);
			6'd32: u = u_mac(R_C, R_SY, MAC_ADD);
			6'd33: u = u_op(OP_ST, R_DET, C_XOFF);
			6'd34: u = u_op(OP_ZT, R_DET, C_XOFF);
			6'd35: u = u_mac(R_A, R_ZX0, MAC_ADD);
			6'd36: u = u_mac(R_B, R_ZXX, MAC_ADD);
			6'd37: u = u_mac(R_C, R_ZXY, MAC_ADD);
			6'd38: u = u_op(OP_DIV, R_DET, C_XOFF);
			6'd39: u = u_mac(R_B, R_ZX0, MAC_ADD);
			6'd40: u = u_mac(R_E, R_ZXX, MAC_ADD);
			6'd41: u = u_mac(R_F, R_ZXY, MAC_ADD);
			6'd42: u = u_op(OP_DIV, R_DET, C_XRX);
			6'd43: u = u_mac(R_C, R_ZX0, MAC_ADD);
			6'd44: u = u_mac(R_F, R_ZXX, MAC_ADD);
			6'd45: u = u_mac(R_I, R_ZXY, MAC_ADD);
			6'd46: u = u_op(OP_DIV, R_DET, C_XRY);
			6'd47: u = u_mac(R_A, R_ZY0, MAC_ADD);
			6'd48: u = u_mac(R_B, R_ZYX, MAC_ADD);
			6'd49: u = u_mac(R_C, R_ZYY, MAC_ADD);
			6'd50: u = u_op(OP_DIV, R_DET, C_YOFF);
			6'd51: u = u_mac(R_B, R_ZY0, MAC_ADD);
			6'd52: u = u_mac(R_E, R_ZYX, MAC_ADD);
			6'd53: u = u_mac(R_F, R_ZYY, MAC_ADD);
			6'd54: u = u_op(OP_DIV, R_DET, C_YRX);
			6'd55: u = u_mac(R_C, R_ZY0, MAC_ADD);
			6'd56: u = u_mac(R_F, R_ZYX, MAC_ADD);
			6'd57: u = u_mac(R_I, R_ZYY, MAC_ADD);
			6'd58: u = u_op(OP_DIV, R_DET, C_YRY);
			default: u = u_op(OP_END, R_N, C_XOFF);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tacs_dp.sv =====
// Datapath: point store, wide register file, bit-serial multiply-accumulate and divider.
// Depends on tacs_pkg.
`default_nettype none
module tacs_dp #(
	parameter int NUM_POINTS = tacs_pkg::NUM_POINTS_DEF,
	parameter int COORD_BITS = tacs_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = tacs_pkg::FRAC_BITS_DEF,
	localparam int PIW = $clog2(NUM_POINTS)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic st_we,
	input  wire logic [PIW-1:0] st_idx,
	input  wire logic [COORD_BITS-1:0] st_rx,
	input  wire logic [COORD_BITS-1:0] st_ry,
	input  wire logic [COORD_BITS-1:0] st_sx,
	input  wire logic [COORD_BITS-1:0] st_sy,
	input  wire tacs_pkg::cmd_t cmd,
	output tacs_pkg::stat_t stat,
	output logic [tacs_pkg::NCOEF-1:0][tacs_pkg::COEF_W-1:0] coef
);
	localparam int W  = tacs_pkg::W;
	localparam int MB = 2 * COORD_BITS + $clog2(NUM_POINTS);
	localparam int CW = $clog2(W);

	typedef enum logic [3:0] {
		D_IDLE, D_SUM, D_RDA, D_RDB, D_MUL, D_DRD, D_DIV, D_SAT, D_ZT
	} dstate_t;

	dstate_t state_q;
	tacs_pkg::uop_t uop_q;
	logic done_q, zero_q, neg_q;
	logic [PIW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] acc_q, mcand_q, rd_q, num_q, rem_q, dmag_q;
	logic [MB-1:0] mplr_q;
	logic [tacs_pkg::NCOEF-1:0][tacs_pkg::COEF_W-1:0] coef_q;

	logic [COORD_BITS-1:0] rx_q [NUM_POINTS];
	logic [COORD_BITS-1:0] ry_q [NUM_POINTS];
	logic [COORD_BITS-1:0] sx_q [NUM_POINTS];
	logic [COORD_BITS-1:0] sy_q [NUM_POINTS];
	logic [W-1:0] rf_q [tacs_pkg::NREG];

	logic [COORD_BITS-1:0] pa, qa;
	logic [2*COORD_BITS-1:0] prod;
	logic sum_last;
	logic rf_we;
	tacs_pkg::reg_t rf_wa, rd_addr;
	logic [W-1:0] rf_wd, scaled;
	logic [W:0] r2;
	logic ge;
	logic big;
	logic [tacs_pkg::COEF_W-1:0] sat;

	always_ff @(posedge clk) begin
		if (st_we) begin
			rx_q[st_idx] <= st_rx;
			ry_q[st_idx] <= st_ry;
			sx_q[st_idx] <= st_sx;
			sy_q[st_idx] <= st_sy;
		end
	end

	function automatic logic [COORD_BITS-1:0] pick(tacs_pkg::src_t s, logic [COORD_BITS-1:0] rx,
			logic [COORD_BITS-1:0] ry, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy);
		logic [COORD_BITS-1:0] v;
		case (s)
			tacs_pkg::SRC_RX: v = rx;
			tacs_pkg::SRC_RY: v = ry;
			tacs_pkg::SRC_SX: v = sx;
			tacs_pkg::SRC_SY: v = sy;
			default:          v = COORD_BITS'(1);
		endcase
		return v;
	endfunction

	always_comb begin
		pa = pick(uop_q.p, rx_q[k_q], ry_q[k_q], sx_q[k_q], sy_q[k_q]);
		qa = pick(uop_q.q, rx_q[k_q], ry_q[k_q], sx_q[k_q], sy_q[k_q]);
		prod = pa * qa;
		sum_last = (k_q == PIW'(NUM_POINTS - 1));
	end

	// One write port: sum results land at the end of a sum, stores on command.
	always_comb begin
		rf_we = 1'b0;
		rf_wa = cmd.uop.ra;
		rf_wd = acc_q;
		if (state_q == D_SUM) begin
			rf_we = sum_last;
			rf_wa = uop_q.ra;
			rf_wd = acc_q + W'(prod);
		end else if (state_q == D_IDLE && cmd.go && cmd.uop.opc == tacs_pkg::OP_ST) begin
			rf_we = 1'b1;
		end
		if (state_q == D_IDLE) begin
			rd_addr = (cmd.uop.opc == tacs_pkg::OP_MAC) ? cmd.uop.ra : tacs_pkg::R_DET;
		end else begin
			rd_addr = uop_q.rb;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[rf_wa] <= rf_wd;
		end
		rd_q <= rf_q[rd_addr];
	end

	always_comb begin
		scaled = acc_q << FRAC_BITS;
		r2 = {rem_q, num_q[W-1]};
		ge = (r2 >= {1'b0, dmag_q});
		big = |num_q[W-1:tacs_pkg::COEF_W];
		if (neg_q) begin
			sat = (big || num_q[tacs_pkg::COEF_W-1:0] > tacs_pkg::SAT_MIN) ? tacs_pkg::SAT_MIN
				: (tacs_pkg::COEF_W'(0) - num_q[tacs_pkg::COEF_W-1:0]);
		end else begin
			sat = (big || num_q[tacs_pkg::COEF_W-1]) ? tacs_pkg::SAT_MAX
				: num_q[tacs_pkg::COEF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (cmd.go) begin
						uop_q <= cmd.uop;
						case (cmd.uop.opc)
							tacs_pkg::OP_SUM: begin
								k_q <= '0;
								acc_q <= '0;
								state_q <= D_SUM;
							end
							tacs_pkg::OP_MAC: state_q <= D_RDA;
							tacs_pkg::OP_ST: begin
								acc_q <= '0;
								done_q <= 1'b1;
							end
							tacs_pkg::OP_ZT:  state_q <= D_ZT;
							tacs_pkg::OP_DIV: state_q <= D_DRD;
							default: done_q <= 1'b1;
						endcase
					end
				end
				D_SUM: begin
					if (sum_last) begin
						acc_q <= '0;
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						acc_q <= acc_q + W'(prod);
						k_q <= k_q + 1'b1;
					end
				end
				D_RDA: begin
					mcand_q <= rd_q;
					state_q <= D_RDB;
				end
				D_RDB: begin
					mplr_q <= rd_q[MB-1:0];
					cnt_q <= '0;
					state_q <= D_MUL;
				end
				D_MUL: begin
					if (mplr_q[0]) begin
						acc_q <= uop_q.neg ? acc_q - mcand_q : acc_q + mcand_q;
					end
					mcand_q <= mcand_q << 1;
					mplr_q <= mplr_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(MB - 1)) begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				D_ZT: begin
					zero_q <= (rd_q == '0);
					done_q <= 1'b1;
					state_q <= D_IDLE;
				end
				D_DRD: begin
					neg_q <= scaled[W-1] ^ rd_q[W-1];
					num_q <= scaled[W-1] ? (W'(0) - scaled) : scaled;
					dmag_q <= rd_q[W-1] ? (W'(0) - rd_q) : rd_q;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= D_DIV;
				end
				D_DIV: begin
					rem_q <= ge ? W'(r2 - {1'b0, dmag_q}) : r2[W-1:0];
					num_q <= {num_q[W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W - 1)) begin
						state_q <= D_SAT;
					end
				end
				D_SAT: begin
					coef_q[uop_q.cidx] <= sat;
					acc_q <= '0;
					done_q <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.det_zero = zero_q;
	assign coef = coef_q;

endmodule
`default_nettype wire

// ===== rtl/core/tacs_ctrl.sv =====
// Controller: steps the solve microprogram and hands finished results to the output stage.
// Depends on tacs_pkg.
`default_nettype none
module tacs_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic out_free,
	input  wire tacs_pkg::stat_t stat,
	output tacs_pkg::cmd_t cmd,
	output tacs_pkg::pub_t pub,
	output logic in_ready
);
	typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_PUB} cstate_t;

	cstate_t state_q;
	logic [tacs_pkg::UPC_W-1:0] pc_q;
	logic ok_q;
	tacs_pkg::cmd_t cmd_q;
	tacs_pkg::pub_t pub_q;
	tacs_pkg::uop_t cur;

	assign cur = tacs_pkg::ucode(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			pc_q <= '0;
			ok_q <= 1'b0;
			cmd_q <= '0;
			pub_q <= '0;
		end else begin
			cmd_q.go <= 1'b0;
			pub_q.valid <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						pc_q <= '0;
						state_q <= C_ISSUE;
					end
				end
				C_ISSUE: begin
					if (cur.opc == tacs_pkg::OP_END) begin
						ok_q <= 1'b1;
						state_q <= C_PUB;
					end else begin
						cmd_q.uop <= cur;
						cmd_q.go <= 1'b1;
						state_q <= C_WAIT;
					end
				end
				C_WAIT: begin
					if (stat.done) begin
						if (cmd_q.uop.opc == tacs_pkg::OP_ZT && stat.det_zero) begin
							ok_q <= 1'b0;
							state_q <= C_PUB;
						end else begin
							pc_q <= pc_q + 1'b1;
							state_q <= C_ISSUE;
						end
					end
				end
				C_PUB: begin
					if (out_free) begin
						pub_q.valid <= 1'b1;
						pub_q.ok <= ok_q;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign cmd = cmd_q;
	assign pub = pub_q;
	assign in_ready = (state_q == C_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/touch_affine_calibration_solver_unit.sv =====
// Top level of the touch calibration solver: stream ports, output register, assertions.
// Depends on tacs_pkg, tacs_ctrl, tacs_dp and assert_macros.svh.
//
//   port group   dir   content
//   s_*          in    one calibration point per transaction, tlast starts the solve
//   m_*          out   one result per solve: six coefficients, scale, ok flag in tuser
//
// A point without tlast is stored when it is accepted and the next one is taken at once.
// A point with tlast starts a solve, whose length is set by the bit-serial multiply-accumulate
// over MB = 2*COORD_BITS + clog2(NUM_POINTS) multiplier bits and by the restoring divider,
// both one bit per cycle.
// Reset clears control only; point slots hold garbage until written.
// A result waits in the output register while new points are taken; a finished solve
// holds until that register is free.
`default_nettype none
module touch_affine_calibration_solver_unit #(
	parameter int NUM_POINTS = tacs_pkg::NUM_POINTS_DEF,
	parameter int COORD_BITS = tacs_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = tacs_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// point_index[2:0], raw_x[14:3], raw_y[26:15], screen_x[38:27], screen_y[50:39]
	input  wire logic [tacs_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic s_tlast,          // last_point
	output logic m_tvalid,
	input  wire logic m_tready,
	// xmap_offset[31:0], xmap_from_raw_x[63:32], xmap_from_raw_y[95:64],
	// ymap_offset[127:96], ymap_from_raw_x[159:128], ymap_from_raw_y[191:160],
	// scale_factor[208:192]
	output logic [tacs_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic m_tuser                // calibration_ok
);
	localparam int PIW = $clog2(NUM_POINTS);
	localparam int CFW = tacs_pkg::NCOEF * tacs_pkg::COEF_W;

	logic in_acc, st_we, start, out_free, in_ready;
	logic [2:0] point_index;
	tacs_pkg::cmd_t cmd;
	tacs_pkg::stat_t stat;
	tacs_pkg::pub_t pub;
	logic [tacs_pkg::NCOEF-1:0][tacs_pkg::COEF_W-1:0] coef;
	logic m_tvalid_q, m_tuser_q;
	logic [tacs_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [tacs_pkg::SCALE_W-1:0] scale;

	assign point_index = s_tdata[2:0];
	assign s_tready = in_ready;
	assign in_acc = s_tvalid && s_tready;
	// Drop points whose slot lies beyond the store.
	assign st_we = in_acc && (32'(point_index) < NUM_POINTS);
	assign start = in_acc && s_tlast;
	assign out_free = !m_tvalid_q || m_tready;
	assign scale = tacs_pkg::SCALE_W'(1) << FRAC_BITS;

	tacs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.pub      (pub),
		.in_ready (in_ready)
	);

	tacs_dp #(
		.NUM_POINTS (NUM_POINTS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.st_we  (st_we),
		.st_idx (PIW'(point_index)),
		.st_rx  (COORD_BITS'(s_tdata[14:3])),
		.st_ry  (COORD_BITS'(s_tdata[26:15])),
		.st_sx  (COORD_BITS'(s_tdata[38:27])),
		.st_sy  (COORD_BITS'(s_tdata[50:39])),
		.cmd    (cmd),
		.stat   (stat),
		.coef   (coef)
	);

	// Output register: load a published result, hold it until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pub.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pub.valid) begin
			m_tuser_q <= pub.ok;
			if (pub.ok) begin
				m_tdata_q <= tacs_pkg::OUT_DATA_W'({scale, CFW'(coef)});
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

`include "assert_macros.svh"

	// A result is only published into a free output register.
	`ASSERT_ALWAYS(a_pub_free, !pub.valid || $past(out_free))
	// The datapath gets no command while points are being taken.
	`ASSERT_ALWAYS(a_no_cmd_idle, !(s_tready && cmd.go))
	// A failed solve shows all-zero coefficients and scale.
	`ASSERT_ALWAYS(a_fail_zero, !(m_tvalid && !m_tuser) || (m_tdata == '0))
	// Once a solve starts, the input stops taking points.
	`ASSERT_NEXT(a_start_busy, start, !s_tready)

endmodule
`default_nettype wire

// ===== verif/tb_touch_affine_calibration_solver_unit.sv =====
// Stream-level testbench of the touch calibration solver: loads calibration points, triggers
// solves and checks every result against an in-bench least-squares predictor.
// Depends on tacs_pkg and touch_affine_calibration_solver_unit.
`default_nettype none
module tb_touch_affine_calibration_solver_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import tacs_pkg::*;

	localparam int NPTS       = NUM_POINTS_DEF;
	localparam int RAND_ITEMS = 750;
	localparam int STALL_LIMIT = 20000;   // covers a solve plus the long receiver hold
	localparam int HOLD_CYCLES = 6000;
	localparam int DRAIN_CYCLES = 3000;
	localparam logic signed [127:0] COEF_MAX = 128'sh7FFF_FFFF;
	localparam logic signed [127:0] COEF_MIN = -128'sh8000_0000;

	typedef struct packed {
		logic [2:0]  idx;
		logic [11:0] rx;
		logic [11:0] ry;
		logic [11:0] sx;
		logic [11:0] sy;
		logic        last;
	} cal_point_t;

	typedef struct packed {
		logic             ok;
		logic [5:0][31:0] coef;
		logic [16:0]      scale;
	} cal_result_t;

	// How the expectation of a directed row is obtained
	typedef enum logic {ROW_PREDICT, ROW_SINGULAR} row_kind_t;

	typedef struct packed {
		cal_point_t pt;
		row_kind_t  kind;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [OUT_DATA_W-1:0] m_tdata;

	touch_affine_calibration_solver_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #4 clk = ~clk;

	// Predictor state: the point slots as the block should hold them
	logic [11:0] slot_rx[NPTS], slot_ry[NPTS], slot_sx[NPTS], slot_sy[NPTS];
	logic [NPTS-1:0] slot_loaded;
	cal_result_t pending_results[$];
	int errors;
	int tx_idle_pct, rx_idle_pct;
	bit hold_go, hold_done;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// trunc(num * 2^16 / det), saturated to 32-bit signed
	function automatic logic [31:0] fixed_quotient(input logic signed [127:0] num,
			input logic signed [127:0] det);
		logic signed [127:0] q;
		q = (num <<< 16) / det;
		if (q > COEF_MAX)
			return SAT_MAX;
		if (q < COEF_MIN)
			return SAT_MIN;
		return q[31:0];
	endfunction

	// Least-squares affine fit over all slots
	function automatic cal_result_t solve_affine_fit();
		logic signed [127:0] n, sx, sy, sxx, syy, sxy, z, zx, zy;
		logic signed [127:0] ma, mb, mc, me, mf, mi, det;
		cal_result_t r;
		r = '0;
		n = NPTS;
		sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
		for (int k = 0; k < NPTS; k++) begin
			sx  += slot_rx[k];
			sy  += slot_ry[k];
			sxx += slot_rx[k] * slot_rx[k];
			syy += slot_ry[k] * slot_ry[k];
			sxy += slot_rx[k] * slot_ry[k];
		end
		// adjugate of the symmetric normal matrix
		ma = sxx * syy - sxy * sxy;
		mb = sxy * sy - sx * syy;
		mc = sx * sxy - sy * sxx;
		me = n * syy - sy * sy;
		mf = sx * sy - n * sxy;
		mi = n * sxx - sx * sx;
		det = n * ma + sx * mb + sy * mc;
		if (det == 0)
			return r;
		r.ok = 1'b1;
		r.scale = 17'd65536;
		for (int axis = 0; axis < 2; axis++) begin
			z = 0; zx = 0; zy = 0;
			for (int k = 0; k < NPTS; k++) begin
				logic [11:0] t;
				t = axis ? slot_sy[k] : slot_sx[k];
				z  += t;
				zx += t * slot_rx[k];
				zy += t * slot_ry[k];
			end
			r.coef[3*axis]   = fixed_quotient(ma * z + mb * zx + mc * zy, det);
			r.coef[3*axis+1] = fixed_quotient(mb * z + me * zx + mf * zy, det);
			r.coef[3*axis+2] = fixed_quotient(mc * z + mf * zx + mi * zy, det);
		end
		return r;
	endfunction

	// Offer one point, wait for its transaction, then update the predictor
	task automatic send_point(input cal_point_t p, input row_kind_t kind);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, p.sy, p.sx, p.ry, p.rx, p.idx};
		s_tlast <= p.last;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		if (p.idx < NPTS) begin
			slot_rx[p.idx] = p.rx;
			slot_ry[p.idx] = p.ry;
			slot_sx[p.idx] = p.sx;
			slot_sy[p.idx] = p.sy;
			slot_loaded[p.idx] = 1'b1;
		end
		if (p.last)
			pending_results.push_back(kind == ROW_SINGULAR ? cal_result_t'('0)
				: solve_affine_fit());
	endtask

	// Coordinate with a bias toward extremes and tight clusters
	function automatic logic [11:0] pick_coord(input int style, input logic [11:0] base);
		case (style)
			0: begin
				return $urandom_range(1) ? 12'hFFF : 12'h000;
			end
			1: begin
				return base ^ 12'($urandom_range(3));
			end
			default: begin
				return 12'($urandom);
			end
		endcase
	endfunction

	// Compare each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(m_tuser), 32'(0));
			end else begin
				cal_result_t want;
				want = pending_results.pop_front();
				if (m_tuser !== want.ok)
					report_mismatch("calibration_ok", 32'(m_tuser), 32'(want.ok));
				for (int k = 0; k < NCOEF; k++)
					if (m_tdata[32*k +: 32] !== want.coef[k])
						report_mismatch($sformatf("coef %0d", k), m_tdata[32*k +: 32],
							want.coef[k]);
				if (m_tdata[208:192] !== want.scale)
					report_mismatch("scale_factor", 32'(m_tdata[208:192]), 32'(want.scale));
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: stop when no transaction moves for too long
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("tb_touch_affine_calibration_solver_unit: errors");
				$finish;
			end
		end
	end

	stim_row_t directed[] = '{
		// identical points: singular normal matrix
		'{'{3'd0, 12'd2048, 12'd2048, 12'd100, 12'd200, 1'b0}, ROW_PREDICT},
		'{'{3'd1, 12'd2048, 12'd2048, 12'd100, 12'd200, 1'b0}, ROW_PREDICT},
		'{'{3'd2, 12'd2048, 12'd2048, 12'd100, 12'd200, 1'b0}, ROW_PREDICT},
		'{'{3'd3, 12'd2048, 12'd2048, 12'd100, 12'd200, 1'b0}, ROW_PREDICT},
		'{'{3'd4, 12'd2048, 12'd2048, 12'd100, 12'd200, 1'b1}, ROW_SINGULAR},
		// out-of-range slot is dropped, solve still runs on stored points
		'{'{3'd7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1}, ROW_SINGULAR},
		// corners and center
		'{'{3'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, ROW_PREDICT},
		'{'{3'd1, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 1'b0}, ROW_PREDICT},
		'{'{3'd2, 12'd0, 12'hFFF, 12'd0, 12'hFFF, 1'b0}, ROW_PREDICT},
		'{'{3'd3, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0}, ROW_PREDICT},
		'{'{3'd4, 12'd2048, 12'd2048, 12'd2048, 12'd2048, 1'b1}, ROW_PREDICT},
		// collinear raw points: singular
		'{'{3'd0, 12'd0, 12'd0, 12'd10, 12'd4000, 1'b0}, ROW_PREDICT},
		'{'{3'd1, 12'd1000, 12'd1000, 12'd900, 12'd30, 1'b0}, ROW_PREDICT},
		'{'{3'd2, 12'd2000, 12'd2000, 12'd77, 12'd1234, 1'b0}, ROW_PREDICT},
		'{'{3'd3, 12'd3000, 12'd3000, 12'd4095, 12'd0, 1'b0}, ROW_PREDICT},
		'{'{3'd4, 12'hFFF, 12'hFFF, 12'd5, 12'd6, 1'b1}, ROW_SINGULAR},
		// raw x nearly constant with swinging screen x: offsets saturate
		'{'{3'd0, 12'd4094, 12'd0, 12'd0, 12'hFFF, 1'b0}, ROW_PREDICT},
		'{'{3'd1, 12'hFFF, 12'd1000, 12'hFFF, 12'd0, 1'b0}, ROW_PREDICT},
		'{'{3'd2, 12'd4094, 12'd2000, 12'd0, 12'hFFF, 1'b0}, ROW_PREDICT},
		'{'{3'd3, 12'hFFF, 12'd3000, 12'hFFF, 12'd0, 1'b0}, ROW_PREDICT},
		'{'{3'd4, 12'd4094, 12'hFFF, 12'd0, 12'hFFF, 1'b1}, ROW_PREDICT},
		// out-of-range slots with and without a solve
		'{'{3'd6, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0}, ROW_PREDICT},
		'{'{3'd5, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, ROW_PREDICT}
	};

	initial begin
		int sent;
		int order[NPTS];
		int style;
		cal_point_t p, anchor;
		errors = 0;
		slot_loaded = '0;
		hold_go = 1'b0;
		hold_done = 1'b0;
		tx_idle_pct = 30;
		rx_idle_pct = 51;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r])
			send_point(directed[r].pt, directed[r].kind);

		// Random part: mostly full five-point calibrations, some stray points
		sent = 0;
		while (sent < RAND_ITEMS) begin
			// idling phases: receiver heavy, sender heavy, then none
			if (sent < RAND_ITEMS / 3) begin
				tx_idle_pct = 30; rx_idle_pct = 51;
			end else if (sent < 2 * RAND_ITEMS / 3) begin
				tx_idle_pct = 51; rx_idle_pct = 30;
			end else begin
				tx_idle_pct = 0; rx_idle_pct = 0;
				if (sent > 4 * RAND_ITEMS / 5)
					hold_go = 1'b1;
			end
			if ($urandom_range(99) < 80) begin
				foreach (order[k])
					order[k] = k;
				order.shuffle();
				style = $urandom_range(5);
				anchor = cal_point_t'(52'({$urandom, $urandom}));
				for (int k = 0; k < NPTS; k++) begin
					p.idx  = 3'(order[k]);
					p.rx   = pick_coord(style, anchor.rx);
					p.ry   = pick_coord(style == 1 && $urandom_range(1) ? 2 : style,
						anchor.ry);
					p.sx   = pick_coord($urandom_range(2), anchor.sx);
					p.sy   = pick_coord($urandom_range(2), anchor.sy);
					p.last = (k == NPTS - 1);
					send_point(p, ROW_PREDICT);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 3)) begin
					p = cal_point_t'(52'({$urandom, $urandom}));
					p.last = ($urandom_range(3) == 0) && (&slot_loaded);
					send_point(p, ROW_PREDICT);
					sent++;
				end
			end
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_touch_affine_calibration_solver_unit: clean");
		else
			$display("tb_touch_affine_calibration_solver_unit: errors");
		$finish;
	end

endmodule
`default_nettype wire

// ===== touch_affine_calibration_solver_unit.f =====
+incdir+rtl/core
rtl/core/tacs_pkg.sv
rtl/core/tacs_dp.sv
rtl/core/tacs_ctrl.sv
rtl/core/touch_affine_calibration_solver_unit.sv
verif/tb_touch_affine_calibration_solver_unit.sv
